[rtl/core/exp_taylor_horner_4lane_macros.svh]
// ----------------------------------------------------------------------------
// exp_taylor_horner_4lane assertion macros
// Shared concurrent assertion forms for the exponential pipeline.
// ----------------------------------------------------------------------------
`ifndef EXP_TAYLOR_HORNER_4LANE_MACROS_SVH
`define EXP_TAYLOR_HORNER_4LANE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ETX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("etx: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ETX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("etx: next-cycle check failed");

`endif

[rtl/core/etx_pkg.sv]
// ----------------------------------------------------------------------------
// etx_pkg
// Types, widths and the series coefficient function for the exponential.
// ----------------------------------------------------------------------------
package etx_pkg;

   localparam int Lanes     = 4;
   localparam int ArgW      = 16;
   localparam int AccW      = 52;
   localparam int QuoW      = 21;
   localparam int ResW      = 32;
   localparam int NumW      = 6;
   localparam int NeffW     = 7;
   localparam int TFrac     = 15;
   localparam int OutFrac   = 20;
   localparam int AccFrac   = 40;
   localparam int GenShift  = 10;

   localparam logic [NumW-1:0] NumTermsReset = 6'd24;
   localparam logic [ResW-1:0] RecipMax      = 32'h0010_0000;

   typedef struct packed {
      logic            neg;
      logic [ArgW-1:0] mag;
      logic [AccW-1:0] acc;
   } etx_lane_type;

   typedef struct packed {
      logic            neg;
      logic [AccW-1:0] acc;
      logic [AccW-1:0] rem;
      logic [QuoW-1:0] quo;
   } etx_div_type;

   typedef etx_lane_type [Lanes-1:0] etx_lanes_type;
   typedef etx_div_type  [Lanes-1:0] etx_divs_type;

   // 8^k/k! in Q24.40, built from a Q50 recursion; used at elaboration only.
   function automatic logic [63:0] coef_at(int k);
      logic [63:0] g;
      logic [63:0] c;
      g = 64'd1 << 50;
      c = 64'd1 << AccFrac;
      for (int j = 1; j <= k; j++) begin
         g = (g * 64'd8 + 64'(j / 2)) / 64'(j);
         c = (g + (64'd1 << (GenShift - 1))) >> GenShift;
      end
      return c;
   endfunction

endpackage

[rtl/core/exp_taylor_horner_4lane.sv]
// ----------------------------------------------------------------------------
// exp_taylor_horner_4lane
// Four-lane exp(x) of Q4.12 arguments by a pipelined Horner Taylor series,
// with a pipelined reciprocal for negative arguments; Q12.20 results.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | direction | word
//   --------+--------------------------------+-----------+---------------------
//   req     | req_valid/ready, req_arg_lane* | in        | four Q4.12 arguments
//   rsp     | rsp_valid/ready, rsp_exp_lane* | out       | four Q12.20 results
//   csr     | csr_valid/ready, csr_num_terms | in        | series order
//
// One word enters per cycle unless a stalled rsp word holds the pipeline; each
// passes through MAX_TERMS+23 register stages: one entry stage, one Horner
// stage per term (a 52x16 multiply-add each), 21 one-bit division stages and
// the output register.
// Synchronous active-high reset clears all valid bits and loads order 24.
// A stalled rsp word freezes the whole pipeline; req_ready drops in that cycle.
// ----------------------------------------------------------------------------
`include "exp_taylor_horner_4lane_macros.svh"

module exp_taylor_horner_4lane #(
   parameter int MAX_TERMS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [15:0]         req_arg_lane0,
   input  logic signed [15:0]         req_arg_lane1,
   input  logic signed [15:0]         req_arg_lane2,
   input  logic signed [15:0]         req_arg_lane3,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [31:0]                rsp_exp_lane0,
   output logic [31:0]                rsp_exp_lane1,
   output logic [31:0]                rsp_exp_lane2,
   output logic [31:0]                rsp_exp_lane3,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [etx_pkg::NumW-1:0]   csr_num_terms
);
   import etx_pkg::*;

   localparam int TabIdxW = $clog2(MAX_TERMS + 1);
   localparam logic [NeffW-1:0] MaxT = NeffW'(MAX_TERMS);
   localparam logic [NeffW-1:0] MinT = NeffW'(2);
   localparam logic [AccW:0]    RoundO = (AccW+1)'(1) << (OutFrac - 1);
   localparam logic [AccW-1:0]  RemSeed = AccW'(1) << (AccFrac + OutFrac - QuoW);

   // order register
   logic [NumW-1:0]  n_ff;
   logic [NeffW-1:0] n_raw, n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= NumTermsReset;
      end else if (csr_valid && csr_ready) begin
         n_ff <= csr_num_terms;
      end
   end

   assign csr_ready = 1'b1;
   assign n_raw     = NeffW'(n_ff);

   // clamp the order into the range the pipeline holds
   always_comb begin
      priority if (n_raw < MinT) begin
         n_eff = MinT;
      end else if (n_raw > MaxT) begin
         n_eff = MaxT;
      end else begin
         n_eff = n_raw;
      end
   end

   // coefficient table, read once per word at the top term
   logic [AccW-1:0] coef_tab [MAX_TERMS+1];
   for (genvar k = 0; k <= MAX_TERMS; k++) begin : g_coef
      assign coef_tab[k] = AccW'(coef_at(k));
   end

   // whole pipeline advances whenever the output slot is free or drains
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // entry stage: magnitude, sign, accumulator seeded with c_n
   logic signed [ArgW-1:0] arg [Lanes];
   etx_lanes_type entry_in, entry_ff;
   logic          entry_valid_ff;

   assign arg[0] = req_arg_lane0;
   assign arg[1] = req_arg_lane1;
   assign arg[2] = req_arg_lane2;
   assign arg[3] = req_arg_lane3;

   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         entry_in[l].neg = arg[l][ArgW-1];
         // the most negative argument wraps to magnitude 8.0 exactly
         entry_in[l].mag = arg[l][ArgW-1] ? (~arg[l] + 1'b1) : arg[l];
         entry_in[l].acc = coef_tab[n_eff[TabIdxW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (adv) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         entry_ff <= entry_in;
      end
   end

   // Horner chain, highest term first
   logic [MAX_TERMS:0] h_valid;
   etx_lanes_type      h_lanes [MAX_TERMS+1];

   assign h_valid[0] = entry_valid_ff;
   assign h_lanes[0] = entry_ff;

   for (genvar j = 0; j < MAX_TERMS; j++) begin : g_horner
      etx_horner_stage #(
         .K (MAX_TERMS - 1 - j)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .n_eff     (n_eff),
         .in_valid  (h_valid[j]),
         .in_lanes  (h_lanes[j]),
         .out_valid (h_valid[j+1]),
         .out_lanes (h_lanes[j+1])
      );
   end

   // reciprocal chain: quotient of (2^60 + acc/2) / acc, MSB first
   logic [QuoW:0] d_valid;
   etx_divs_type  d_divs [QuoW+1];
   etx_divs_type  div_seed;

   assign d_valid[0] = h_valid[MAX_TERMS];
   assign d_divs[0]  = div_seed;

   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         div_seed[l].neg = h_lanes[MAX_TERMS][l].neg;
         div_seed[l].acc = h_lanes[MAX_TERMS][l].acc;
         // numerator shifted down by the quotient width
         div_seed[l].rem = RemSeed | (h_lanes[MAX_TERMS][l].acc >> (QuoW + 1));
         div_seed[l].quo = '0;
      end
   end

   for (genvar i = 0; i < QuoW; i++) begin : g_recip
      etx_recip_stage #(
         .BIT (QuoW - 1 - i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (d_valid[i]),
         .in_divs   (d_divs[i]),
         .out_valid (d_valid[i+1]),
         .out_divs  (d_divs[i+1])
      );
   end

   // output register: pick reciprocal or rounded, saturated accumulator
   logic [AccW:0]   rnd    [Lanes];
   logic [ResW-1:0] res_in [Lanes];
   logic [ResW-1:0] rsp_exp_ff [Lanes];
   logic [Lanes-1:0] out_neg_ff;

   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         rnd[l] = {1'b0, d_divs[QuoW][l].acc} + RoundO;
         priority if (d_divs[QuoW][l].neg) begin
            res_in[l] = ResW'(d_divs[QuoW][l].quo);
         end else if (rnd[l][AccW]) begin
            res_in[l] = '1;
         end else begin
            res_in[l] = rnd[l][AccW-1:OutFrac];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d_valid[QuoW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < Lanes; l++) begin
            rsp_exp_ff[l] <= res_in[l];
            out_neg_ff[l] <= d_divs[QuoW][l].neg;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_exp_lane0 = rsp_exp_ff[0];
   assign rsp_exp_lane1 = rsp_exp_ff[1];
   assign rsp_exp_lane2 = rsp_exp_ff[2];
   assign rsp_exp_lane3 = rsp_exp_ff[3];

   // hold every stage while the output word waits
   `ETX_ASSERT_NXT(a_stall_holds, clock, reset, !adv, $stable(h_valid) && $stable(d_valid))
   // clamped order always within the pipeline depth
   `ETX_ASSERT_IMP(a_order_range, clock, reset, 1'b1, (n_eff >= MinT) && (n_eff <= MaxT))
   // a negative argument in lane 0 never yields more than 1.0
   `ETX_ASSERT_IMP(a_recip_bound, clock, reset, rsp_valid_ff && out_neg_ff[0], rsp_exp_ff[0] <= RecipMax)

endmodule

[rtl/core/etx_horner_stage.sv]
// ----------------------------------------------------------------------------
// etx_horner_stage
// One Horner step for all lanes: acc = c_K + round(acc * mag / 2^15) when K is below the order.
// ----------------------------------------------------------------------------
module etx_horner_stage #(
   parameter int K = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic [etx_pkg::NeffW-1:0]  n_eff,
   input  logic                       in_valid,
   input  etx_pkg::etx_lanes_type     in_lanes,
   output logic                       out_valid,
   output etx_pkg::etx_lanes_type     out_lanes
);
   import etx_pkg::*;

   localparam int PW = AccW + ArgW;
   localparam logic [AccW-1:0]  CoefK  = AccW'(coef_at(K));
   localparam logic [NeffW-1:0] KIdx   = NeffW'(K);
   localparam logic [PW-1:0]    RoundT = PW'(1) << (TFrac - 1);

   logic [PW-1:0]  prod [Lanes];
   logic [PW-1:0]  sum  [Lanes];
   etx_lanes_type  lanes_in, lanes_ff;
   logic           valid_ff;

   always_comb begin
      lanes_in = in_lanes;
      for (int l = 0; l < Lanes; l++) begin
         prod[l] = PW'(in_lanes[l].acc) * PW'(in_lanes[l].mag);
         sum[l]  = PW'(CoefK) + ((prod[l] + RoundT) >> TFrac);
         // terms at or above the order pass the accumulator through
         if (KIdx < n_eff) begin
            lanes_in[l].acc = sum[l][AccW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lanes = lanes_ff;

endmodule

[rtl/core/etx_recip_stage.sv]
// ----------------------------------------------------------------------------
// etx_recip_stage
// One restoring-division step for all lanes, producing quotient bit BIT.
// ----------------------------------------------------------------------------
module etx_recip_stage #(
   parameter int BIT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  etx_pkg::etx_divs_type  in_divs,
   output logic                   out_valid,
   output etx_pkg::etx_divs_type  out_divs
);
   import etx_pkg::*;

   logic [AccW:0]  rem_sh [Lanes];
   logic [AccW:0]  diff   [Lanes];
   etx_divs_type   divs_in, divs_ff;
   logic           valid_ff;

   always_comb begin
      divs_in = in_divs;
      for (int l = 0; l < Lanes; l++) begin
         // numerator bit BIT of 2^60 + acc/2 is acc bit BIT+1
         rem_sh[l] = {in_divs[l].rem, in_divs[l].acc[BIT+1]};
         diff[l]   = rem_sh[l] - {1'b0, in_divs[l].acc};
         if (rem_sh[l] >= {1'b0, in_divs[l].acc}) begin
            divs_in[l].rem      = diff[l][AccW-1:0];
            divs_in[l].quo[BIT] = 1'b1;
         end else begin
            divs_in[l].rem      = rem_sh[l][AccW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         divs_ff <= divs_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_divs  = divs_ff;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-lane Taylor exponential: drives argument
// words with random idling, predicts each result word with a fixed-point
// Horner model and compares every lane, across several series orders.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MaxTerms  = 32;
   localparam int Latency   = MaxTerms + 23;
   localparam int WatchLim  = 20000;

   typedef struct packed {
      logic [15:0] a0, a1, a2, a3;
   } arg_word_type;

   typedef struct packed {
      logic [31:0] e0, e1, e2, e3;
   } exp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic signed [15:0] req_arg_lane0 = '0, req_arg_lane1 = '0;
   logic signed [15:0] req_arg_lane2 = '0, req_arg_lane3 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_exp_lane0, rsp_exp_lane1, rsp_exp_lane2, rsp_exp_lane3;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [etx_pkg::NumW-1:0] csr_num_terms = '0;

   arg_word_type arg_pending[$];
   exp_word_type exp_awaited[$];
   logic [5:0]  order_reg = etx_pkg::NumTermsReset;
   logic [63:0] coef_tab[0:MaxTerms];
   int          error_count = 0;
   int          words_checked = 0;
   int          idle_cycles = 0;
   int          req_gap = 0, rsp_gap = 0;
   bit          calm = 1'b0;
   bit          csr_done;

   always #5 clock = ~clock;

   exp_taylor_horner_4lane #(.MAX_TERMS(MaxTerms)) u_top (.*);

   // Rebuild the 8^k/k! table in Q24.40 from the Q50 recursion.
   task automatic build_coef_tab();
      logic [63:0] g;
      g = 64'd1 << 50;
      coef_tab[0] = 64'd1 << 40;
      for (int k = 1; k <= MaxTerms; k++) begin
         g = (g * 64'd8 + 64'(k / 2)) / 64'(k);
         coef_tab[k] = (g + 64'd512) >> 10;
      end
   endtask

   function automatic logic [31:0] lane_exp(logic [15:0] raw, int order);
      logic        neg;
      logic [63:0] mag, h, r;
      neg = raw[15];
      mag = neg ? (64'h10000 - 64'(raw)) : 64'(raw);
      h = coef_tab[order];
      for (int k = order - 1; k >= 0; k--)
         h = coef_tab[k] + (h >> 15) * mag + (((h & 64'h7FFF) * mag + 64'h4000) >> 15);
      if (neg)
         r = ((64'd1 << 60) + (h >> 1)) / h;
      else
         r = (h + (64'd1 << 19)) >> 20;
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   function automatic exp_word_type predict_exp(arg_word_type w);
      int order;
      exp_word_type e;
      order = (order_reg < 2) ? 2 : (order_reg > MaxTerms) ? MaxTerms : order_reg;
      e.e0 = lane_exp(w.a0, order);
      e.e1 = lane_exp(w.a1, order);
      e.e2 = lane_exp(w.a2, order);
      e.e3 = lane_exp(w.a3, order);
      return e;
   endfunction

   // Driver: present the next pending word, holding it until accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            exp_awaited.push_back(predict_exp(arg_pending.pop_front()));
         end
         if (!req_valid || req_ready) begin
            // The word just consumed is already popped; the next one is at the front.
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (arg_pending.size() > 0) begin
               arg_word_type w;
               w = arg_pending[0];
               req_valid <= 1'b1;
               {req_arg_lane0, req_arg_lane1, req_arg_lane2, req_arg_lane3} <= w;
               if (!calm && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            exp_word_type got, want;
            got = {rsp_exp_lane0, rsp_exp_lane1, rsp_exp_lane2, rsp_exp_lane3};
            if (exp_awaited.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, got);
               error_count++;
            end else begin
               want = exp_awaited.pop_front();
               for (int i = 0; i < 4; i++)
                  if (want[127-32*i -: 32] !== got[127-32*i -: 32]) begin
                     $display("%0t: lane %0d expected %h actual %h", $time, i,
                              want[127-32*i -: 32], got[127-32*i -: 32]);
                     error_count++;
                  end
               words_checked++;
            end
         end
         // Stall the response side in bursts, none once calm.
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) rsp_gap <= $urandom_range(1, 9);
         end
      end
   end

   // Watchdog: count cycles with no handshake on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLim) begin
         $display("%0t: watchdog expired", $time);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_order(logic [5:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_num_terms <= v;
      csr_done = 1'b0;
      while (!csr_done) begin
         @(posedge clock);
         if (csr_ready) csr_done = 1'b1;
      end
      csr_valid <= 1'b0;
      order_reg = v;
   endtask

   // Wait for the pipe to drain, then for its latency.
   task automatic drain();
      while (arg_pending.size() != 0 || exp_awaited.size() != 0 || req_valid)
         @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_arg();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_random(int count);
      arg_word_type w;
      for (int i = 0; i < count; i++) begin
         w = {rand_arg(), rand_arg(), rand_arg(), rand_arg()};
         arg_pending.push_back(w);
      end
   endtask

   logic [5:0] orders[6] = '{6'd0, 6'd63, 6'd2, 6'd32, 6'd1, 6'd33};

   initial begin
      build_coef_tab();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // Directed: zero, extremes, small values, at the reset order.
      arg_pending.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0000});
      arg_pending.push_back({16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF});
      arg_pending.push_back({16'h1000, 16'hF000, 16'h4000, 16'hC000});
      arg_pending.push_back({16'h7000, 16'h9000, 16'h5555, 16'hAAAA});
      queue_random(200);
      drain();
      foreach (orders[i]) begin
         write_order(orders[i]);
         arg_pending.push_back({16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
         queue_random(180);
         drain();
      end
      // A random order, then a calm tail with no idling.
      write_order(6'($urandom_range(2, 40)));
      queue_random(200);
      drain();
      calm = 1'b1;
      write_order(etx_pkg::NumTermsReset);
      queue_random(100);
      drain();
      $display("Checked %0d result words over orders 0 to 63, incl. clamped ones,",
               words_checked);
      $display("with extreme, zero and random arguments under random idling.");
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
